>>> hw/rtl/hsc_pkg.sv
`timescale 1ns / 1ps

package hsc_pkg;

  localparam int unsigned HSC_ROUNDS = 6;
  localparam int unsigned HSC_QBITS = 8;
  localparam int unsigned HSC_LANES = 3;

  localparam logic [31:0] HSC_C0 = 32'h7ed55d16;
  localparam logic [31:0] HSC_C1 = 32'hc761c23c;
  localparam logic [31:0] HSC_C2 = 32'h165667b1;
  localparam logic [31:0] HSC_C3 = 32'hd3a2646c;
  localparam logic [31:0] HSC_C4 = 32'hfd7046c5;
  localparam logic [31:0] HSC_C5 = 32'hb55a4f09;

  // 0.15 and 0.75 intensity, 0.1 alpha, greys 1.0 / 0.2 / 0.66, all as trunc(v*255)
  localparam logic [7:0] HSC_K_STATIC = 8'd38;
  localparam logic [7:0] HSC_K_DYNAMIC = 8'd191;
  localparam logic [7:0] HSC_GREY_FULL = 8'd255;
  localparam logic [7:0] HSC_ALPHA_SENSOR = 8'd25;
  localparam logic [7:0] HSC_GREY_SLEEP = 8'd51;
  localparam logic [7:0] HSC_GREY_DROWSY = 8'd168;
  localparam logic [7:0] HSC_ALPHA_OPAQUE = 8'd255;

  typedef enum logic [1:0] {
    KIND_SENSOR,
    KIND_SLEEP,
    KIND_DROWSY,
    KIND_HASH
  } hsc_kind_t;

  // side-band that travels with each beat down the chain
  typedef struct packed {
    hsc_kind_t  kind;
    logic [7:0] k;
    logic       flat;
  } hsc_tok_t;

  typedef logic [HSC_LANES-1:0][15:0] hsc_rem_t;
  typedef logic [HSC_LANES-1:0][7:0]  hsc_quo_t;

  function automatic logic [31:0] hsc_mix_round(input int unsigned rnd, input logic [31:0] a);
    logic [31:0] res;
    case (rnd)
      0: res = (a + HSC_C0) + (a << 12);
      1: res = (a ^ HSC_C1) ^ (a >> 19);
      2: res = (a + HSC_C2) + (a << 5);
      3: res = (a + HSC_C3) ^ (a << 9);
      4: res = (a + HSC_C4) + (a << 3);
      5: res = (a ^ HSC_C5) ^ (a >> 16);
      default: res = a;
    endcase
    return res;
  endfunction

endpackage

>>> hw/rtl/hashed_shape_color.sv
`timescale 1ns / 1ps

// Debug colour for one physics object, fully pipelined.
//
// Input beat: start high while busy is low takes in_object_id and the status
// flags. busy is high only while rst_n is low, so a new beat may be given in
// every cycle: one beat per clock, sustained.
// Result beat: out_valid is high for one cycle with out_red/green/blue/alpha;
// it rises once the beat has passed every cell of the chain below. The
// receiver cannot stall; every result is taken at the end of its cycle.
// The chain holds six hash cells (one mixing round each), one
// min/max and scaling cell, eight divide cells (one quotient bit each, three
// lanes side by side) and the output register.
// Config: cfg_we writes cfg_wdata into the drowsy idle-time threshold;
// change it only when no beat is in flight.
// Reset (synchronous, rst_n low) empties the chain and sets the threshold
// to all ones, so nothing shows as drowsy until it is written.
module hashed_shape_color
  import hsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_object_id,
  input  logic        in_is_sensor,
  input  logic        in_is_sleeping,
  input  logic [31:0] in_idle_time,
  input  logic        in_is_static,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha
);

  logic [31:0] thr_r;

  // hash chain: index 0 is the entry point, index HSC_ROUNDS the last cell
  logic     [HSC_ROUNDS:0]       mix_vld;
  logic     [HSC_ROUNDS:0][31:0] mix_hash;
  hsc_tok_t [HSC_ROUNDS:0]       mix_tok;
  hsc_tok_t                      entry_tok;

  // divide chain: index 0 fed by the span cell
  logic     [HSC_QBITS:0]      div_vld;
  logic     [HSC_QBITS:0][7:0] div_span;
  hsc_rem_t [HSC_QBITS:0]      div_rem;
  hsc_quo_t [HSC_QBITS:0]      div_quo;
  hsc_tok_t [HSC_QBITS:0]      div_tok;

  hsc_tok_t   last_tok;
  hsc_quo_t   last_quo;
  logic [7:0] red_nxt, green_nxt, blue_nxt, alpha_nxt;

  logic       out_valid_r;
  logic [7:0] red_r, green_r, blue_r, alpha_r;

  assign busy = !rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '1;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // classify on entry; priority is sensor, sleeping, drowsy, hashed
  always_comb begin
    entry_tok.flat = 1'b0;
    entry_tok.k    = in_is_static ? HSC_K_STATIC : HSC_K_DYNAMIC;
    if (in_is_sensor) begin
      entry_tok.kind = KIND_SENSOR;
    end else if (in_is_sleeping) begin
      entry_tok.kind = KIND_SLEEP;
    end else if (in_idle_time > thr_r) begin
      entry_tok.kind = KIND_DROWSY;
    end else begin
      entry_tok.kind = KIND_HASH;
    end
  end

  assign mix_tok[0]  = entry_tok;
  assign mix_vld[0]  = start && !busy;
  assign mix_hash[0] = in_object_id;

  for (genvar g = 0; g < HSC_ROUNDS; g++) begin : g_mix
    hsc_mix_cell #(
      .ROUND(g)
    ) u_mix (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (mix_vld[g]),
      .in_hash (mix_hash[g]),
      .in_tok  (mix_tok[g]),
      .out_vld (mix_vld[g+1]),
      .out_hash(mix_hash[g+1]),
      .out_tok (mix_tok[g+1])
    );
  end

  hsc_span_cell u_span (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (mix_vld[HSC_ROUNDS]),
    .in_hash (mix_hash[HSC_ROUNDS]),
    .in_tok  (mix_tok[HSC_ROUNDS]),
    .out_vld (div_vld[0]),
    .out_span(div_span[0]),
    .out_rem (div_rem[0]),
    .out_tok (div_tok[0])
  );

  assign div_quo[0] = '0;

  // MSB first: cell g settles quotient bit HSC_QBITS-1-g
  for (genvar g = 0; g < HSC_QBITS; g++) begin : g_div
    hsc_div_cell #(
      .BIT(HSC_QBITS - 1 - g)
    ) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (div_vld[g]),
      .in_span (div_span[g]),
      .in_rem  (div_rem[g]),
      .in_quo  (div_quo[g]),
      .in_tok  (div_tok[g]),
      .out_vld (div_vld[g+1]),
      .out_span(div_span[g+1]),
      .out_rem (div_rem[g+1]),
      .out_quo (div_quo[g+1]),
      .out_tok (div_tok[g+1])
    );
  end

  assign last_tok = div_tok[HSC_QBITS];
  assign last_quo = div_quo[HSC_QBITS];

  always_comb begin
    alpha_nxt = HSC_ALPHA_OPAQUE;
    case (last_tok.kind)
      KIND_SENSOR: begin
        red_nxt   = HSC_GREY_FULL;
        green_nxt = HSC_GREY_FULL;
        blue_nxt  = HSC_GREY_FULL;
        alpha_nxt = HSC_ALPHA_SENSOR;
      end
      KIND_SLEEP: begin
        red_nxt   = HSC_GREY_SLEEP;
        green_nxt = HSC_GREY_SLEEP;
        blue_nxt  = HSC_GREY_SLEEP;
      end
      KIND_DROWSY: begin
        red_nxt   = HSC_GREY_DROWSY;
        green_nxt = HSC_GREY_DROWSY;
        blue_nxt  = HSC_GREY_DROWSY;
      end
      default: begin
        // all three bytes equal: no span to stretch, show pure red at K
        if (last_tok.flat) begin
          red_nxt   = last_tok.k;
          green_nxt = '0;
          blue_nxt  = '0;
        end else begin
          red_nxt   = last_quo[0];
          green_nxt = last_quo[1];
          blue_nxt  = last_quo[2];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_vld[HSC_QBITS];
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
    alpha_r <= alpha_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;
  assign out_alpha = alpha_r;

endmodule

>>> hw/rtl/hsc_mix_cell.sv
`timescale 1ns / 1ps

module hsc_mix_cell
  import hsc_pkg::*;
#(
  parameter int unsigned ROUND = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [31:0] in_hash,
  input  hsc_tok_t    in_tok,
  output logic        out_vld,
  output logic [31:0] out_hash,
  output hsc_tok_t    out_tok
);

  logic        vld_r;
  logic [31:0] hash_r;
  logic [31:0] hash_nxt;
  hsc_tok_t    tok_r;

  assign hash_nxt = hsc_mix_round(ROUND, in_hash);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
    tok_r  <= in_tok;
  end

  assign out_vld  = vld_r;
  assign out_hash = hash_r;
  assign out_tok  = tok_r;

endmodule

>>> hw/rtl/hsc_span_cell.sv
`timescale 1ns / 1ps

module hsc_span_cell
  import hsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [31:0] in_hash,
  input  hsc_tok_t    in_tok,
  output logic        out_vld,
  output logic [7:0]  out_span,
  output hsc_rem_t    out_rem,
  output hsc_tok_t    out_tok
);

  logic [HSC_LANES-1:0][7:0] chan;
  logic [7:0] mx;
  logic [7:0] mn;
  logic [7:0] span_nxt;
  hsc_rem_t   rem_nxt;
  hsc_tok_t   tok_nxt;

  logic       vld_r;
  logic [7:0] span_r;
  hsc_rem_t   rem_r;
  hsc_tok_t   tok_r;

  always_comb begin
    chan[0] = in_hash[7:0];
    chan[1] = in_hash[15:8];
    chan[2] = in_hash[23:16];
    mx = (chan[0] > chan[1]) ? chan[0] : chan[1];
    mx = (mx > chan[2]) ? mx : chan[2];
    mn = (chan[0] < chan[1]) ? chan[0] : chan[1];
    mn = (mn < chan[2]) ? mn : chan[2];
    span_nxt = mx - mn;
    for (int i = 0; i < HSC_LANES; i++) begin
      rem_nxt[i] = 16'(chan[i] - mn) * 16'(in_tok.k);
    end
    tok_nxt = in_tok;
    tok_nxt.flat = (mx == mn);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    span_r <= span_nxt;
    rem_r  <= rem_nxt;
    tok_r  <= tok_nxt;
  end

  assign out_vld  = vld_r;
  assign out_span = span_r;
  assign out_rem  = rem_r;
  assign out_tok  = tok_r;

endmodule

>>> hw/rtl/hsc_div_cell.sv
`timescale 1ns / 1ps

// One restoring-division step for each colour lane: settles quotient bit BIT.
module hsc_div_cell
  import hsc_pkg::*;
#(
  parameter int unsigned BIT = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_vld,
  input  logic [7:0] in_span,
  input  hsc_rem_t   in_rem,
  input  hsc_quo_t   in_quo,
  input  hsc_tok_t   in_tok,
  output logic       out_vld,
  output logic [7:0] out_span,
  output hsc_rem_t   out_rem,
  output hsc_quo_t   out_quo,
  output hsc_tok_t   out_tok
);

  logic [15:0] dvs;
  hsc_rem_t    rem_nxt;
  hsc_quo_t    quo_nxt;

  logic        vld_r;
  logic [7:0]  span_r;
  hsc_rem_t    rem_r;
  hsc_quo_t    quo_r;
  hsc_tok_t    tok_r;

  always_comb begin
    dvs = 16'(in_span) << BIT;
    for (int i = 0; i < HSC_LANES; i++) begin
      if (in_rem[i] >= dvs) begin
        rem_nxt[i] = in_rem[i] - dvs;
        quo_nxt[i] = in_quo[i] | (8'd1 << BIT);
      end else begin
        rem_nxt[i] = in_rem[i];
        quo_nxt[i] = in_quo[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    span_r <= in_span;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    tok_r  <= in_tok;
  end

  assign out_vld  = vld_r;
  assign out_span = span_r;
  assign out_rem  = rem_r;
  assign out_quo  = quo_r;
  assign out_tok  = tok_r;

endmodule

>>> hw/rtl/hsc_checker.sv
`timescale 1ns / 1ps

module hsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha
);

  // every taken beat comes out as a result beat
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##16 out_valid)
    else $error("result beat missing");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 16))
    else $error("result beat without an input beat");

  a_reset_flush: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("result beat straight after reset");

  // translucent only for a sensor, which is full white
  a_sensor_white: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_alpha != 8'd255) |->
      (out_alpha == 8'd25 && out_red == 8'd255 && out_green == 8'd255 &&
       out_blue == 8'd255))
    else $error("bad sensor colour");

endmodule

bind hashed_shape_color hsc_checker u_hsc_checker (.*);
